@@ rtl/core/iimg_pkg.sv @@
// shared constants, types and helpers of the rgb integral image block
package iimg_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int SIZE_W = 12;
  localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int PIX_W   = 8;
  localparam int PSQ_W   = 2 * PIX_W;
  localparam int SUM_W   = 30;
  localparam int SQ_W    = 38;
  localparam int LSQ_W   = 39;
  localparam int NCH     = 3;
  localparam int IN_W    = NCH * PIX_W;
  localparam int OUT_RAW = NCH * (SUM_W + SQ_W);
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_AW = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [NCH-1:0][PIX_W-1:0] pix;
    logic [NCH-1:0][PSQ_W-1:0] sq;
    logic [COL_W-1:0]          col;
    logic                      first_col;
    logic                      first_row;
    logic                      frame_end;
  } item_t;

  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] sum;
    logic [NCH-1:0][LSQ_W-1:0] sq;
  } line_t;

  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] sum;
    logic [NCH-1:0][SQ_W-1:0]  sq;
    logic                      frame_end;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/iimg_front.sv @@
// front end: size registers, pixel position counters and per-channel squares
module iimg_front import iimg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  q_full,
  output logic                  in_ready,
  output logic                  q_push,
  output item_t                 q_item
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              last_col;
  logic              last_row;

  assign w_eff = clamp_size(width_r,  SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  assign last_col = 32'(col_r) >= 32'(w_eff) - 32'd1;
  assign last_row = 32'(row_r) >= 32'(h_eff) - 32'd1;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      q_item.pix[c] = in_data[c*PIX_W +: PIX_W];
      q_item.sq[c]  = PSQ_W'(in_data[c*PIX_W +: PIX_W]) * PSQ_W'(in_data[c*PIX_W +: PIX_W]);
    end
    q_item.col       = col_r;
    q_item.first_col = (col_r == '0);
    q_item.first_row = (row_r == '0);
    q_item.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/iimg_queue.sv @@
// short item queue between front and back end
module iimg_queue import iimg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output item_t head
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/iimg_back.sv @@
// back end: row sums, line store read/add/write-back and output register
module iimg_back import iimg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] rs;
    logic [NCH-1:0][LSQ_W-1:0] rsq;
    logic [COL_W-1:0]          col;
    logic                      first_row;
    logic                      frame_end;
  } stage_t;

  line_t   line_mem [MAX_WIDTH];
  line_t   rd_q_r;
  line_t   byp_r;
  logic    byp_hit_r;
  line_t   above;
  line_t   total;

  logic [NCH-1:0][SUM_W-1:0] rs_r;
  logic [NCH-1:0][LSQ_W-1:0] rsq_r;
  logic [NCH-1:0][SUM_W-1:0] rs_nxt;
  logic [NCH-1:0][LSQ_W-1:0] rsq_nxt;

  stage_t  s1_r;
  logic    s1_v_r;
  result_t out_r;
  logic    out_v_r;
  logic    adv;

  assign adv   = s1_v_r && (!out_v_r || out_ready);
  assign q_pop = q_valid && (!s1_v_r || adv);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      rs_nxt[c]  = (q_item.first_col ? '0 : rs_r[c])  + SUM_W'(q_item.pix[c]);
      rsq_nxt[c] = (q_item.first_col ? '0 : rsq_r[c]) + LSQ_W'(q_item.sq[c]);
    end
  end

  // newest write bypasses the memory when it lands on the column being read
  always_comb begin
    above = byp_hit_r ? byp_r : rd_q_r;
    if (s1_r.first_row) begin
      above = '0;
    end
    for (int c = 0; c < NCH; c++) begin
      total.sum[c] = s1_r.rs[c]  + above.sum[c];
      total.sq[c]  = s1_r.rsq[c] + above.sq[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_mem[s1_r.col] <= total;
    end
    if (q_pop) begin
      rd_q_r <= line_mem[q_item.col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byp_r <= total;
      s1_r  <= '{rs: rs_nxt, rsq: rsq_nxt, col: q_item.col,
                 first_row: q_item.first_row, frame_end: q_item.frame_end};
    end
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        out_r.sum[c] <= total.sum[c];
        out_r.sq[c]  <= total.sq[c][SQ_W-1:0];
      end
      out_r.frame_end <= s1_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r      <= '0;
      rsq_r     <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rs_r      <= rs_nxt;
        rsq_r     <= rsq_nxt;
        byp_hit_r <= adv && (s1_r.col == q_item.col);
      end
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_result = out_r;

endmodule

@@ rtl/core/rgb_integral_image.sv @@
// top level of the rgb integral image block
//
//  port group  dir  payload (low bit first)
//  in_*        in   red[7:0], green[15:8], blue[23:16]
//  out_*       out  sum_red, sum_green, sum_blue (30 each), square_red, square_green,
//                   square_blue (38 each), zero fill to 208; frame_end on out_tlast
//  cfg_*       in   index 0 image_width, index 1 image_height, 12-bit data
//
// one item per cycle sustained while the output accepts; each accepted item passes the queue,
// then the line store read, then the add into the output register, before it is offered
// the line store read of one column and the write-back of the previous item share a cycle
// reset is synchronous and clears counters, row sums and all valid flags
// a stalled output holds the back end; the four-entry queue keeps the input open until it fills
module rgb_integral_image import iimg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // red, green, blue
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // sum_red, sum_green, sum_blue, square_red,
                                            // square_green, square_blue, zero fill
  output logic                  out_tlast
);

  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;
  logic    full;
  logic    q_valid;
  result_t res;

  iimg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .q_full    (full),
    .in_ready  (in_tready),
    .q_push    (push),
    .q_item    (push_item)
  );

  iimg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .valid     (q_valid),
    .head      (head)
  );

  iimg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  always_comb begin
    out_tdata = '0;
    for (int c = 0; c < NCH; c++) begin
      out_tdata[c*SUM_W +: SUM_W]                = res.sum[c];
      out_tdata[NCH*SUM_W + c*SQ_W +: SQ_W]      = res.sq[c];
    end
  end

  assign out_tlast = res.frame_end;

endmodule

@@ rtl/core/iimg_checker.sv @@
// port-level checker for the rgb integral image block, with its bind
module iimg_checker import iimg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic              out_tlast
);

  logic frame_start_r;
  logic out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_acc) begin
      frame_start_r <= out_tlast;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && frame_start_r |->
      (out_tdata[SUM_W-1:0] < SUM_W'(256)) &&
      (out_tdata[NCH*SUM_W +: SQ_W] < SQ_W'(65536)))
    else $error("first item of a frame carries more than one pixel");

  a_sq_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[NCH*SUM_W +: SQ_W] >= SQ_W'(out_tdata[0 +: SUM_W])) &&
      (out_tdata[NCH*SUM_W + SQ_W +: SQ_W] >= SQ_W'(out_tdata[SUM_W +: SUM_W])) &&
      (out_tdata[NCH*SUM_W + 2*SQ_W +: SQ_W] >= SQ_W'(out_tdata[2*SUM_W +: SUM_W])))
    else $error("squared integral below plain integral");

endmodule

bind rgb_integral_image iimg_checker u_iimg_checker (.*);
